/* rtl/core/msqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msqd_pkg
// Shared types and constants of the multi-server queue dispatcher.
// ----------------------------------------------------------------------------
package msqd_pkg;

  localparam int unsigned DefServers     = 4;
  localparam int unsigned DefQueueDepth  = 16;
  localparam int unsigned ItemQueueDepth = 2;

  localparam int unsigned CustW    = 16;
  localparam int unsigned SelW     = 2;
  localparam int unsigned CfgW     = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned WaitOutW = 7;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_DEPART  = 1'b1
  } item_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_SERVED   = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DEP_IDLE = 3'd3,
    ST_DEP_NEXT = 3'd4,
    ST_DEP_NOOP = 3'd5
  } status_e;

  typedef enum logic {
    BK_EXEC  = 1'b0,
    BK_FETCH = 1'b1
  } back_state_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [CustW-1:0] customer;
    logic [SelW-1:0]  sel;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queued_item_t;

endpackage

/* rtl/core/msqd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msqd_front
// Accepts requests, classifies them and holds them in a short item queue.
// ----------------------------------------------------------------------------
module msqd_front import msqd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [CustW-1:0] customer_id_i,
  input  logic [SelW-1:0]  server_sel_i,
  input  logic             pop_i,
  output queued_item_t     head_o
);

  localparam int unsigned IqAw = (ItemQueueDepth > 1) ? $clog2(ItemQueueDepth) : 1;

  item_t           slot_q [ItemQueueDepth];
  logic [IqAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [IqAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [IqAw:0]   fill_q, fill_d;
  logic            push;
  item_t           new_item;

  function automatic logic [IqAw-1:0] ptr_inc(input logic [IqAw-1:0] p);
    return (p == IqAw'(ItemQueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Classify: fields that the command ignores are cleared.
  always_comb begin
    new_item = '0;
    if (cmd_i) begin
      new_item.kind = KIND_DEPART;
      new_item.sel  = server_sel_i;
    end else begin
      new_item.kind     = KIND_ARRIVAL;
      new_item.customer = customer_id_i;
    end
  end

  assign in_stall_o = (fill_q == (IqAw + 1)'(ItemQueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = push  ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule

/* rtl/core/msqd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msqd_back
// Executes requests: server and queue state, queue store, result register.
// ----------------------------------------------------------------------------
module msqd_back import msqd_pkg::*; #(
  parameter int unsigned SERVERS     = DefServers,
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CfgW-1:0]     active_servers_i,
  input  queued_item_t        head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [SelW-1:0]     server_idx_o,
  output logic [SelW-1:0]     queue_index_o,
  output logic [CustW-1:0]    started_customer_o,
  output logic [CustW-1:0]    departed_customer_o,
  output logic [WaitOutW-1:0] waiting_total_o
);

  localparam int unsigned SrvW       = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int unsigned TreeLeaves = 1 << SrvW;
  localparam int unsigned PtrW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WaitW      = $clog2(SERVERS * QUEUE_DEPTH + 1);
  localparam int unsigned MemAw      = SrvW + PtrW;
  localparam int unsigned MemDepth   = 1 << MemAw;
  localparam int unsigned NactW      = SrvW + 1;

  // Server and queue state
  logic [SERVERS-1:0] busy_q;
  logic [CustW-1:0]   cust_q [SERVERS];
  logic [PtrW-1:0]    head_q [SERVERS];
  logic [PtrW-1:0]    tail_q [SERVERS];
  logic [CntW-1:0]    cnt_q  [SERVERS];
  logic [WaitW-1:0]   waiting_q;

  // Queue store
  logic [CustW-1:0]   mem [MemDepth];
  logic [CustW-1:0]   rd_q;
  logic               mem_we, mem_re;
  logic [MemAw-1:0]   wr_addr, rd_addr;

  back_state_e        state_q, state_d;
  logic [SrvW-1:0]    pend_sel_q;
  logic               out_free, exec_go, fetch_go;

  // Search results
  logic [NactW-1:0]   n_act;
  logic [SERVERS-1:0] act;
  logic               idle_found, pull_found;
  logic [SrvW-1:0]    idle_idx, pull_idx, min_idx, sel_w;
  logic               min_full, sel_ok;
  logic [CntW:0]      leaf_key [TreeLeaves];
  logic [CntW:0]      key  [1:2*TreeLeaves-1];
  logic [SrvW-1:0]    kidx [1:2*TreeLeaves-1];

  // Resolved result of the item at the head of the queue
  status_e            res_status;
  logic [SelW-1:0]    res_srv, res_q;
  logic [CustW-1:0]   res_started, res_departed;
  logic [WaitW-1:0]   res_wait;

  // Result register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [SelW-1:0]    out_srv_q, out_q_q;
  logic [CustW-1:0]   out_started_q, out_departed_q;
  logic [WaitW-1:0]   out_wait_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Out-of-range register values clamp to 1..SERVERS
  always_comb begin
    if (active_servers_i == '0) begin
      n_act = NactW'(1);
    end else if (int'(active_servers_i) > int'(SERVERS)) begin
      n_act = NactW'(SERVERS);
    end else begin
      n_act = NactW'(active_servers_i);
    end
    for (int i = 0; i < SERVERS; i++) begin
      act[i] = (NactW'(i) < n_act);
    end
  end

  // Lowest idle active server; lowest non-empty active queue
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    pull_found = 1'b0;
    pull_idx   = '0;
    for (int i = SERVERS - 1; i >= 0; i--) begin
      if (act[i] && !busy_q[i]) begin
        idle_found = 1'b1;
        idle_idx   = SrvW'(i);
      end
      if (act[i] && (cnt_q[i] != '0)) begin
        pull_found = 1'b1;
        pull_idx   = SrvW'(i);
      end
    end
  end

  // Shortest active queue: compare tree, inactive leaves carry the top bit
  for (genvar g = 0; g < TreeLeaves; g++) begin : g_leaf
    if (g < SERVERS) begin : g_real
      assign leaf_key[g] = act[g] ? {1'b0, cnt_q[g]} : {1'b1, {CntW{1'b0}}};
    end else begin : g_pad
      assign leaf_key[g] = {1'b1, {CntW{1'b0}}};
    end
  end

  always_comb begin
    for (int l = 0; l < TreeLeaves; l++) begin
      key[TreeLeaves + l]  = leaf_key[l];
      kidx[TreeLeaves + l] = SrvW'(l);
    end
    for (int n = TreeLeaves - 1; n >= 1; n--) begin
      // ties keep the left (lower) index
      if (key[2*n+1] < key[2*n]) begin
        key[n]  = key[2*n+1];
        kidx[n] = kidx[2*n+1];
      end else begin
        key[n]  = key[2*n];
        kidx[n] = kidx[2*n];
      end
    end
  end

  assign min_idx  = kidx[1];
  assign min_full = (key[1][CntW-1:0] == CntW'(QUEUE_DEPTH));

  assign sel_w  = SrvW'(head_i.item.sel);
  assign sel_ok = (int'(head_i.item.sel) < int'(n_act)) && busy_q[sel_w];

  always_comb begin
    res_status   = ST_DEP_NOOP;
    res_srv      = '0;
    res_q        = '0;
    res_started  = '0;
    res_departed = '0;
    res_wait     = waiting_q;
    case (head_i.item.kind)
      KIND_ARRIVAL: begin
        if (idle_found) begin
          res_status  = ST_SERVED;
          res_srv     = SelW'(idle_idx);
          res_started = head_i.item.customer;
        end else begin
          res_q = SelW'(min_idx);
          if (min_full) begin
            res_status = ST_DROPPED;
          end else begin
            res_status = ST_QUEUED;
            res_wait   = waiting_q + 1'b1;
          end
        end
      end
      KIND_DEPART: begin
        res_srv = head_i.item.sel;
        if (sel_ok) begin
          res_departed = cust_q[sel_w];
          if (pull_found) begin
            res_status = ST_DEP_NEXT;
            res_q      = SelW'(pull_idx);
            res_wait   = waiting_q - 1'b1;
          end else begin
            res_status = ST_DEP_IDLE;
          end
        end
      end
      default: res_status = ST_DEP_NOOP;
    endcase
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_EXEC:  if (exec_go && (res_status == ST_DEP_NEXT)) state_d = BK_FETCH;
      BK_FETCH: state_d = BK_EXEC;
      default:  state_d = BK_EXEC;
    endcase
  end

  // Sequencer: outputs
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    exec_go  = 1'b0;
    fetch_go = 1'b0;
    case (state_q)
      BK_EXEC:  exec_go  = head_i.valid && out_free;
      BK_FETCH: fetch_go = 1'b1;
      default:  exec_go  = 1'b0;
    endcase
  end

  assign pop_o   = exec_go;
  assign mem_we  = exec_go && (res_status == ST_QUEUED);
  assign mem_re  = exec_go && (res_status == ST_DEP_NEXT);
  assign wr_addr = {min_idx, tail_q[min_idx]};
  assign rd_addr = {pull_idx, head_q[pull_idx]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= head_i.item.customer;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EXEC;
      busy_q      <= '0;
      waiting_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        waiting_q   <= res_wait;
        out_valid_q <= (res_status != ST_DEP_NEXT);
        case (res_status)
          ST_SERVED:   busy_q[idle_idx] <= 1'b1;
          ST_QUEUED: begin
            tail_q[min_idx] <= ptr_inc(tail_q[min_idx]);
            cnt_q[min_idx]  <= cnt_q[min_idx] + 1'b1;
          end
          ST_DEP_IDLE: busy_q[sel_w] <= 1'b0;
          ST_DEP_NEXT: begin
            head_q[pull_idx] <= ptr_inc(head_q[pull_idx]);
            cnt_q[pull_idx]  <= cnt_q[pull_idx] - 1'b1;
          end
          default: ;
        endcase
      end else if (fetch_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_status_q   <= res_status;
      out_srv_q      <= res_srv;
      out_q_q        <= res_q;
      out_started_q  <= res_started;
      out_departed_q <= res_departed;
      out_wait_q     <= res_wait;
      pend_sel_q     <= sel_w;
      if (res_status == ST_SERVED) begin
        cust_q[idle_idx] <= head_i.item.customer;
      end
    end else if (fetch_go) begin
      out_started_q      <= rd_q;
      cust_q[pend_sel_q] <= rd_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign server_idx_o        = out_srv_q;
  assign queue_index_o       = out_q_q;
  assign started_customer_o  = out_started_q;
  assign departed_customer_o = out_departed_q;
  assign waiting_total_o     = WaitOutW'(out_wait_q);

endmodule

/* rtl/core/multi_server_queue_dispatcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_server_queue_dispatcher_top
// Join-idle-then-shortest-queue dispatcher: front end with item queue,
// execution back end, active-server register.
// ----------------------------------------------------------------------------
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o | cmd_i, customer_id_i, server_sel_i
//   out      | out_valid_o/out_stall_i | status_o, server_idx_o,
//            |                         | queue_index_o, started_customer_o,
//            |                         | departed_customer_o, waiting_total_o
//   cfg      | cfg_valid_i/cfg_ready_o | cfg_data_i (active servers)
//
// An arrival or a departure that pulls no one is done in the back end's
// execute state; a departure that pulls a waiting customer also passes
// through the fetch state, for the registered read of the queue store. A
// request reaches the back end through a 2-entry item queue; in_stall_o
// rises when it is full. The back end waits while out_stall_i holds a
// result; a new one can load at the edge that takes the old. After reset
// all servers are idle and all queues empty; there is no clearing pass.
//
module multi_server_queue_dispatcher_top import msqd_pkg::*; #(
  parameter int unsigned SERVERS     = DefServers,
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [CustW-1:0]    customer_id_i,
  input  logic [SelW-1:0]     server_sel_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [SelW-1:0]     server_idx_o,
  output logic [SelW-1:0]     queue_index_o,
  output logic [CustW-1:0]    started_customer_o,
  output logic [CustW-1:0]    departed_customer_o,
  output logic [WaitOutW-1:0] waiting_total_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i
);

  // Reset value is the full server count, saturated to the register width.
  localparam logic [CfgW-1:0] ActiveReset =
    CfgW'((SERVERS > ((1 << CfgW) - 1)) ? ((1 << CfgW) - 1) : SERVERS);

  logic [CfgW-1:0] active_servers_q;
  queued_item_t    head;
  logic            pop;

  // Writes must arrive only while the block is idle; the block does not enforce it, and the port is always open.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_servers_q <= ActiveReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_servers_q <= cfg_data_i;
    end
  end

  // Front end: takes requests, classifies them, queues them
  msqd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .customer_id_i (customer_id_i),
    .server_sel_i  (server_sel_i),
    .pop_i         (pop),
    .head_o        (head)
  );

  // Back end: searches, state update, queue store, result register
  msqd_back #(
    .SERVERS     (SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .active_servers_i    (active_servers_q),
    .head_i              (head),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .server_idx_o        (server_idx_o),
    .queue_index_o       (queue_index_o),
    .started_customer_o  (started_customer_o),
    .departed_customer_o (departed_customer_o),
    .waiting_total_o     (waiting_total_o)
  );

endmodule

/* rtl/core/msqd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msqd_assert
// Port-level checks on the dispatcher results.
// ----------------------------------------------------------------------------
module msqd_assert import msqd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [StatusW-1:0]  status_o,
  input logic [SelW-1:0]     server_idx_o,
  input logic [SelW-1:0]     queue_index_o,
  input logic [CustW-1:0]    started_customer_o,
  input logic [CustW-1:0]    departed_customer_o,
  input logic [WaitOutW-1:0] waiting_total_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(started_customer_o) && $stable(waiting_total_o))
    else $error("stalled result changed");

  // a queued or dropped arrival starts and releases nobody
  a_queue_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_QUEUED || status_o == ST_DROPPED) |->
      server_idx_o == '0 && started_customer_o == '0 && departed_customer_o == '0)
    else $error("queued/dropped result carries server data");

  // departure on an idle or inactive server touches no customer or queue
  a_noop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DEP_NOOP |->
      queue_index_o == '0 && started_customer_o == '0 && departed_customer_o == '0)
    else $error("idle-server departure carries data");

  // immediate service or idle departure draws from no queue
  a_noqueue_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SERVED || status_o == ST_DEP_IDLE) |->
      queue_index_o == '0)
    else $error("queue index set without queue access");

endmodule

bind multi_server_queue_dispatcher_top msqd_assert u_msqd_checker (.*);

/* sim/msqd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msqd_checker
// Watches the request, result and register channels of the dispatcher,
// keeps its own copy of servers and queues, and compares every result.
// ----------------------------------------------------------------------------
module msqd_checker import msqd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_stall_i,
  input  logic                req_cmd_i,
  input  logic [CustW-1:0]    req_customer_i,
  input  logic [SelW-1:0]     req_sel_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_stall_i,
  input  logic [StatusW-1:0]  rsp_status_i,
  input  logic [SelW-1:0]     rsp_server_i,
  input  logic [SelW-1:0]     rsp_queue_i,
  input  logic [CustW-1:0]    rsp_started_i,
  input  logic [CustW-1:0]    rsp_departed_i,
  input  logic [WaitOutW-1:0] rsp_waiting_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int                  fail_count_o,
  output int                  outstanding_o,
  output int                  results_o,
  output int                  drops_o
);

  localparam int unsigned NumSrv = DefServers;
  localparam int unsigned QDepth = DefQueueDepth;
  localparam int          ShowMax = 40;

  typedef struct packed {
    status_e               status;
    logic [SelW-1:0]       srv;
    logic [SelW-1:0]       qidx;
    logic [CustW-1:0]      started;
    logic [CustW-1:0]      departed;
    logic [WaitOutW-1:0]   waiting;
  } dispatch_result_t;

  dispatch_result_t due_results[$];

  logic [CfgW-1:0]  active_reg;
  logic             srv_busy  [NumSrv];
  logic [CustW-1:0] srv_cust  [NumSrv];
  logic [CustW-1:0] wait_store[NumSrv][QDepth];
  int unsigned      wait_head [NumSrv];
  int unsigned      wait_tail [NumSrv];
  int unsigned      wait_count[NumSrv];
  int               shown;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    results_o     = 0;
    drops_o       = 0;
    shown         = 0;
  end

  function automatic int unsigned servers_in_use();
    if (active_reg == '0) return 1;
    if (active_reg > NumSrv) return NumSrv;
    return 32'(active_reg);
  endfunction

  function automatic int unsigned wrap_next(input int unsigned p);
    return (p + 1 >= QDepth) ? 0 : p + 1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (shown < ShowMax) $display("[%0t] checker: %s", $time, msg);
    else if (shown == ShowMax) $display("[%0t] checker: further mismatches not shown", $time);
    shown++;
    fail_count_o++;
  endtask

  // one event per request, exactly one result
  task automatic predict_dispatch(input item_kind_e kind, input logic [CustW-1:0] cid,
                                  input logic [SelW-1:0] sel);
    dispatch_result_t r;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      total;
    bit               found;
    r     = '0;
    n     = servers_in_use();
    found = 1'b0;
    pick  = 0;
    if (kind == KIND_ARRIVAL) begin
      for (int i = 0; i < n; i++) begin
        if (!found && !srv_busy[i]) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (found) begin
        srv_busy[pick] = 1'b1;
        srv_cust[pick] = cid;
        r.status       = ST_SERVED;
        r.srv          = SelW'(pick);
        r.started      = cid;
      end else begin
        // shortest active queue, lowest index on a tie
        for (int i = 1; i < n; i++) begin
          if (wait_count[i] < wait_count[pick]) pick = i;
        end
        r.qidx = SelW'(pick);
        if (wait_count[pick] >= QDepth) begin
          r.status = ST_DROPPED;
          drops_o++;
        end else begin
          wait_store[pick][wait_tail[pick]] = cid;
          wait_tail[pick] = wrap_next(wait_tail[pick]);
          wait_count[pick]++;
          r.status = ST_QUEUED;
        end
      end
    end else begin
      r.srv = sel;
      if (sel >= n || !srv_busy[sel]) begin
        r.status = ST_DEP_NOOP;
      end else begin
        r.departed = srv_cust[sel];
        for (int i = 0; i < n; i++) begin
          if (!found && wait_count[i] != 0) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (found) begin
          r.started = wait_store[pick][wait_head[pick]];
          wait_head[pick] = wrap_next(wait_head[pick]);
          wait_count[pick]--;
          srv_cust[sel] = r.started;
          r.qidx   = SelW'(pick);
          r.status = ST_DEP_NEXT;
        end else begin
          srv_busy[sel] = 1'b0;
          r.status      = ST_DEP_IDLE;
        end
      end
    end
    // inactive queues still count
    total = 0;
    for (int i = 0; i < NumSrv; i++) total += wait_count[i];
    r.waiting = WaitOutW'(total);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic check_result();
    dispatch_result_t w;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with no request pending (status %0d)", rsp_status_i));
      return;
    end
    w = due_results.pop_front();
    if (rsp_status_i !== w.status)
      report_mismatch($sformatf("status expected %0d got %0d", w.status, rsp_status_i));
    if (rsp_server_i !== w.srv)
      report_mismatch($sformatf("server_idx expected %0d got %0d", w.srv, rsp_server_i));
    if (rsp_queue_i !== w.qidx)
      report_mismatch($sformatf("queue_index expected %0d got %0d", w.qidx, rsp_queue_i));
    if (rsp_started_i !== w.started)
      report_mismatch($sformatf("started_customer expected %h got %h",
                                w.started, rsp_started_i));
    if (rsp_departed_i !== w.departed)
      report_mismatch($sformatf("departed_customer expected %h got %h",
                                w.departed, rsp_departed_i));
    if (rsp_waiting_i !== w.waiting)
      report_mismatch($sformatf("waiting_total expected %0d got %0d",
                                w.waiting, rsp_waiting_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_reg = CfgW'(NumSrv);
      for (int i = 0; i < NumSrv; i++) begin
        srv_busy[i]   = 1'b0;
        srv_cust[i]   = '0;
        wait_head[i]  = 0;
        wait_tail[i]  = 0;
        wait_count[i] = 0;
      end
      due_results.delete();
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) active_reg = cfg_data_i;
      // older result first, the new request cannot have answered yet
      if (rsp_valid_i && !rsp_stall_i) begin
        check_result();
        results_o++;
      end
      if (req_valid_i && !req_stall_i)
        predict_dispatch(item_kind_e'(req_cmd_i), req_customer_i, req_sel_i);
      outstanding_o = due_results.size();
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives arrivals, departures and active-server settings into the dispatcher
// with random gaps and stalls; the checker beside it judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import msqd_pkg::*;

  localparam int NumPhases  = 12;
  localparam int PhaseItems = 162;
  localparam int HoldCycles = 80;   // long receiver hold-off to fill the block

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                cmd_i;
  logic [CustW-1:0]    customer_id_i;
  logic [SelW-1:0]     server_sel_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [StatusW-1:0]  status_o;
  logic [SelW-1:0]     server_idx_o;
  logic [SelW-1:0]     queue_index_o;
  logic [CustW-1:0]    started_customer_o;
  logic [CustW-1:0]    departed_customer_o;
  logic [WaitOutW-1:0] waiting_total_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i;

  int fail_count;
  int outstanding;
  int results_seen;
  int drops_seen;

  // shared between the request process and the result-side process
  bit calm;       // no idling on either side
  bit hold_req;   // ask the result side for one long hold-off

  int requests_sent;
  int settings_written;

  // register settings per random phase: out-of-range values, both extremes
  logic [CfgW-1:0] phase_setting [NumPhases] = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3,
                                                 3'd4, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};
  // percentage of arrivals per phase: high to fill queues, low to drain them
  int arrival_pct [NumPhases] = '{70, 40, 72, 35, 60, 30, 75, 45, 80, 35, 55, 30};

  multi_server_queue_dispatcher_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .cmd_i               (cmd_i),
    .customer_id_i       (customer_id_i),
    .server_sel_i        (server_sel_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .server_idx_o        (server_idx_o),
    .queue_index_o       (queue_index_o),
    .started_customer_o  (started_customer_o),
    .departed_customer_o (departed_customer_o),
    .waiting_total_o     (waiting_total_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  msqd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_stall_i    (in_stall_o),
    .req_cmd_i      (cmd_i),
    .req_customer_i (customer_id_i),
    .req_sel_i      (server_sel_i),
    .rsp_valid_i    (out_valid_o),
    .rsp_stall_i    (out_stall_i),
    .rsp_status_i   (status_o),
    .rsp_server_i   (server_idx_o),
    .rsp_queue_i    (queue_index_o),
    .rsp_started_i  (started_customer_o),
    .rsp_departed_i (departed_customer_o),
    .rsp_waiting_i  (waiting_total_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .results_o      (results_seen),
    .drops_o        (drops_seen)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Run stopped at the time limit");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request.
  // The hold is counted here, independent of the request process, so the
  // item queue fills and in_stall_o has to rise.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i = !calm && ($urandom_range(0, 99) < 19);
      end
    end
  end

  // Offer one request; returns at the falling edge after it was taken.
  // Valid may drop first, never while a request waits.
  task automatic send_request(input item_kind_e kind, input logic [CustW-1:0] cid,
                              input logic [SelW-1:0] sel);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    cmd_i         = kind;
    customer_id_i = cid;
    server_sel_i  = sel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // Register write only once the block has drained.
  task automatic write_active(input logic [CfgW-1:0] value);
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    settings_written++;
  endtask

  initial begin
    int unsigned in_use;
    int          pct;
    // every input known from time zero
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = KIND_ARRIVAL;
    customer_id_i    = '0;
    server_sel_i     = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    requests_sent    = 0;
    settings_written = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed: four servers ----
    write_active(3'd4);
    send_request(KIND_DEPART,  16'h1234, 2'd0);  // departure on an idle server
    send_request(KIND_ARRIVAL, 16'h0000, 2'd3);  // lowest id, served by server 0
    send_request(KIND_ARRIVAL, 16'hFFFF, 2'd0);  // highest id, served by server 1
    send_request(KIND_DEPART,  16'h0000, 2'd1);  // departs, nobody waiting
    send_request(KIND_DEPART,  16'hFFFF, 2'd3);  // idle server 3

    // ---- directed: register 0 behaves as one server ----
    write_active(3'd0);
    // server 0 already busy: sixteen join queue 0, the next is dropped
    for (int k = 0; k < 17; k++) send_request(KIND_ARRIVAL, CustW'(16'hA000 + k), 2'd0);
    send_request(KIND_ARRIVAL, 16'h5A5A, 2'd2);  // one more drop
    send_request(KIND_DEPART,  16'h0000, 2'd0);  // departs and pulls head of queue 0
    send_request(KIND_DEPART,  16'h0000, 2'd2);  // server beyond the active set

    // ---- random phases ----
    for (int p = 0; p < NumPhases; p++) begin
      write_active(phase_setting[p]);
      in_use = (phase_setting[p] == '0) ? 1 :
               (phase_setting[p] > DefServers) ? DefServers : phase_setting[p];
      pct  = arrival_pct[p];
      calm = (p == 4);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 99) < pct)
          send_request(KIND_ARRIVAL, CustW'($urandom), SelW'($urandom_range(0, 3)));
        else if ($urandom_range(0, 99) < 85)
          // mostly departures from servers in use
          send_request(KIND_DEPART, CustW'($urandom), SelW'($urandom_range(0, in_use - 1)));
        else
          send_request(KIND_DEPART, CustW'($urandom), SelW'($urandom_range(0, 3)));
      end
    end
    calm       = 1'b0;
    in_valid_i = 1'b0;

    // drain, then keep waiting to catch stray results
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Covered %0d requests over %0d register settings; %0d results checked, %0d drops.",
             requests_sent, settings_written, results_seen, drops_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, outstanding);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/msqd_pkg.sv
rtl/core/msqd_front.sv
rtl/core/msqd_back.sv
rtl/core/multi_server_queue_dispatcher_top.sv
rtl/core/msqd_checker.sv
sim/msqd_checker.sv
sim/testbench.sv
